[rtl/crc8_checked_frame_receiver_macros.svh]
// assertion macros for the crc-8 frame receiver
`ifndef CRC8_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC8_CHECKED_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define CRC8F_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("crc8f check failed");

// checked at every edge, reset included
`define CRC8F_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("crc8f check failed");

`else

`define CRC8F_ASSERT(label, prop)
`define CRC8F_ASSERT_ALWAYS(label, prop)

`endif

`endif

[rtl/crc8f_pkg.sv]
// shared types and constants of the crc-8 frame receiver
package crc8f_pkg;

    localparam int unsigned POS_W   = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TIMER_W = 8;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd2;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD     = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [POS_W-1:0]  position;
        logic              frame_end;
        t_status           status;
        logic [BYTE_W-1:0] crc_computed;
    } t_result;

endpackage

[rtl/crc8f_engine.sv]
// frame state registers, crc update, timeout timer and result build
`include "crc8_checked_frame_receiver_macros.svh"

module crc8f_engine #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  crc8f_pkg::t_cmd                   i_cmd,
    input  logic [crc8f_pkg::BYTE_W-1:0]      i_byte,
    input  logic [crc8f_pkg::TIMER_W-1:0]     i_timeout_ticks,
    output logic                              o_res_valid,
    output crc8f_pkg::t_result                o_res
);
    import crc8f_pkg::*;

    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [BYTE_W-1:0]  CRC_POLY = 8'h8C;
    localparam logic [TIMER_W-1:0] TIMER_ONE = TIMER_W'(1);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [BYTE_W-1:0]  r_crc,   n_crc;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [BYTE_W-1:0]  crc_upd;

    // reflected crc-8, one byte, lsb first
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    assign crc_upd = crc8_byte(r_crc, i_byte);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_timer     = r_timer;
        o_res_valid = 1'b0;
        o_res       = '{byte_out: i_byte, position: r_pos, frame_end: 1'b0,
                        status: ST_BUSY, crc_computed: crc_upd};
        priority if (i_cmd == CMD_TICK) begin
            if (r_timer != '0) begin
                n_timer = r_timer - TIMER_ONE;
                if (r_timer == TIMER_ONE) begin
                    // timer ran out mid-frame
                    o_res_valid = 1'b1;
                    o_res = '{byte_out: '0, position: r_pos, frame_end: 1'b1,
                              status: ST_TIMEOUT, crc_computed: r_crc};
                    n_pos = '0;
                    n_crc = '0;
                end
            end
        end else if (r_pos >= LAST_POS) begin
            // last byte carries the check value
            o_res_valid = 1'b1;
            o_res = '{byte_out: i_byte, position: r_pos, frame_end: 1'b1,
                      status: (i_byte == r_crc) ? ST_OK : ST_BAD,
                      crc_computed: r_crc};
            n_pos   = '0;
            n_crc   = '0;
            n_timer = '0;
        end else begin
            o_res_valid = 1'b1;
            n_crc   = crc_upd;
            n_pos   = r_pos + POS_W'(1);
            n_timer = i_timeout_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= '0;
            r_timer <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_timer <= n_timer;
        end
    end

    `CRC8F_ASSERT(a_pos_in_frame, r_pos <= LAST_POS)
    `CRC8F_ASSERT(a_end_clears_state,
        (i_fire && o_res_valid && o_res.frame_end) |=>
        (r_pos == '0 && r_crc == '0 && r_timer == '0))
    `CRC8F_ASSERT(a_idle_tick_silent,
        (i_cmd == CMD_TICK && r_timer == '0) |-> !o_res_valid)

endmodule

[rtl/crc8f_out_reg.sv]
// result register toward the output channel
module crc8f_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  crc8f_pkg::t_result  i_res,
    input  logic                i_out_ready,
    output logic                o_space,
    output logic                o_valid,
    output crc8f_pkg::t_result  o_res
);
    import crc8f_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_space = !r_valid || i_out_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/crc8_checked_frame_receiver.sv]
// top level of the crc-8 checked fixed-length frame receiver
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ---------------------------------
// in        input      i_in_valid / o_in_ready    i_command, i_data_byte
// out       output     o_out_valid / i_out_ready  o_byte_out, o_position,
//                                                 o_frame_end, o_status, o_crc_computed
// cfg       input      i_cfg_we                   i_cfg_wdata (timeout_ticks)
//
// one beat per cycle sustained while the output does not stall; a byte beat's result
// goes through the input register, then the crc/state logic into the result register
// the unrolled 8-bit crc update between the input and result registers sets the rate
// synchronous active-low reset clears position, crc, timer and all valid flags;
// timeout_ticks returns to 2
// an output stall holds the result register, then the input register, then o_in_ready
// a tick that produces no result never waits on the output side
`include "crc8_checked_frame_receiver_macros.svh"

module crc8_checked_frame_receiver #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [crc8f_pkg::TIMER_W-1:0]      i_cfg_wdata,
    // input beats
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [crc8f_pkg::BYTE_W-1:0]       i_data_byte,
    // result beats
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [crc8f_pkg::BYTE_W-1:0]       o_byte_out,
    output logic [crc8f_pkg::POS_W-1:0]        o_position,
    output logic                               o_frame_end,
    output logic [1:0]                         o_status,
    output logic [crc8f_pkg::BYTE_W-1:0]       o_crc_computed
);
    import crc8f_pkg::*;

    // timeout register
    logic [TIMER_W-1:0] r_timeout_ticks;

    // input register
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_byte;

    logic    res_valid;
    t_result res;
    logic    out_space;
    logic    advance;
    t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout_ticks <= i_cfg_wdata;
        end
    end

    // the held beat moves on when it yields nothing or the result register has room
    assign advance    = r_in_valid && (!res_valid || out_space);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_byte <= i_data_byte;
        end
    end

    crc8f_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (advance),
        .i_cmd           (r_cmd),
        .i_byte          (r_byte),
        .i_timeout_ticks (r_timeout_ticks),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    crc8f_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_space     (out_space),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_byte_out     = out_res.byte_out;
    assign o_position     = out_res.position;
    assign o_frame_end    = out_res.frame_end;
    assign o_status       = out_res.status;
    assign o_crc_computed = out_res.crc_computed;

endmodule
